// ===== hdl/gb5_pkg.sv =====
// Shared types and constants for the 5x5 Gaussian blur stream core.
// Holds the controller/datapath command and status structs and the weight mux.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gb5_pkg;

   localparam int PIX_W    = 8;
   localparam int WEIGHT_W = 16;
   localparam int SIZE_W   = 12;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 5;
   localparam int TAP_W    = 3;
   localparam int WPROD_W  = 2 * WEIGHT_W;
   localparam int TERM_W   = WPROD_W + PIX_W;
   localparam int ACC_W    = TERM_W + 5;
   localparam int FRAC_W   = 32;

   localparam logic [TAP_W-1:0] TAP_LAST = 3'd4;
   localparam logic [TAP_W-1:0] TAP_HALF = 3'd2;

   // Operation codes of an input item.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_WEIGHT_CENTER = 3'd2;
   localparam logic [2:0] REG_WEIGHT_NEAR   = 3'd3;
   localparam logic [2:0] REG_WEIGHT_FAR    = 3'd4;

   localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH   = 12'd640;
   localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT  = 12'd480;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CENTER = 16'd26386;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_NEAR   = 16'd16004;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_FAR    = 16'd3571;

   typedef struct packed {
      logic             latch;
      logic             check;
      logic             div_start;
      logic             div_step;
      logic             tap_go;
      logic [TAP_W-1:0] tap_row;
      logic [TAP_W-1:0] tap_col;
      logic             acc_clear;
      logic             load_out;
   } gb5_cmd_type;

   typedef struct packed {
      logic out_due;
      logic out_free;
   } gb5_stat_type;

   // One-dimensional weight of a tap offset 0..4 (far, near, center, near, far).
   function automatic logic [WEIGHT_W-1:0] weight_sel(
      input logic [TAP_W-1:0]    idx,
      input logic [WEIGHT_W-1:0] w_center,
      input logic [WEIGHT_W-1:0] w_near,
      input logic [WEIGHT_W-1:0] w_far
   );
      logic [WEIGHT_W-1:0] w;
      case (idx)
         3'd1, 3'd3: w = w_near;
         3'd2:       w = w_center;
         default:    w = w_far;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/gb5_stream_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface gb5_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] pixel_value;
   modport source (output valid, output op, output pixel_value, input ready);
   modport sink   (input valid, input op, input pixel_value, output ready);
endinterface

interface gb5_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blurred_pixel;
   logic       last;
   modport source (output valid, output blurred_pixel, output last, input ready);
   modport sink   (input valid, input blurred_pixel, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/gaussian_blur_5x5_stream_core.sv =====
// An item that completes a result passes through the check, the evaluation, the CW-step
// divider (CW is the position counter width, 23 at the default sizes), the 25 taps and
// the drain, then waits for a free output register; other items end after the evaluation.
// One item is in work at a time: the divider and the 25 taps read one by one from the history memory set the rate.
// Reset (synchronous, active high) clears the frame position, the handshakes and the
// registers to their defaults; the history memory is not cleared and needs no pass.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_5x5_stream_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire                         clock,
   input  wire                         reset,
   gb5_req_if.sink                     req_bus,
   gb5_rsp_if.source                   rsp_bus,
   input  wire                         csr_psel,
   input  wire                         csr_penable,
   input  wire                         csr_pwrite,
   input  wire [gb5_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire [gb5_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [gb5_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import gb5_pkg::*;

   // Configuration registers. A write lands at the access phase of an APB transfer;
   // the index is the word address.
   logic [SIZE_W-1:0]   frame_width_ff, frame_height_ff;
   logic [WEIGHT_W-1:0] weight_center_ff, weight_near_ff, weight_far_ff;
   logic [2:0]          reg_idx;

   assign reg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= RST_FRAME_WIDTH;
         frame_height_ff  <= RST_FRAME_HEIGHT;
         weight_center_ff <= RST_WEIGHT_CENTER;
         weight_near_ff   <= RST_WEIGHT_NEAR;
         weight_far_ff    <= RST_WEIGHT_FAR;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            REG_FRAME_WIDTH:   frame_width_ff   <= csr_pwdata[SIZE_W-1:0];
            REG_FRAME_HEIGHT:  frame_height_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_WEIGHT_CENTER: weight_center_ff <= csr_pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_NEAR:   weight_near_ff   <= csr_pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_FAR:    weight_far_ff    <= csr_pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Reads return the register contents; unused addresses read as zero.
   always_comb begin
      case (reg_idx)
         REG_FRAME_WIDTH:   csr_prdata = CSR_DW'(frame_width_ff);
         REG_FRAME_HEIGHT:  csr_prdata = CSR_DW'(frame_height_ff);
         REG_WEIGHT_CENTER: csr_prdata = CSR_DW'(weight_center_ff);
         REG_WEIGHT_NEAR:   csr_prdata = CSR_DW'(weight_near_ff);
         REG_WEIGHT_FAR:    csr_prdata = CSR_DW'(weight_far_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // The controller sequences each transfer; the datapath holds all the arithmetic.
   gb5_cmd_type  cmd;
   gb5_stat_type stat;
   logic         req_ready;

   assign req_bus.ready = req_ready;

   gb5_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gb5_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .frame_width   (frame_width_ff),
      .frame_height  (frame_height_ff),
      .weight_center (weight_center_ff),
      .weight_near   (weight_near_ff),
      .weight_far    (weight_far_ff),
      .in_op         (req_bus.op),
      .in_pixel      (req_bus.pixel_value),
      .out_valid     (rsp_bus.valid),
      .out_pixel     (rsp_bus.blurred_pixel),
      .out_last      (rsp_bus.last),
      .out_ready     (rsp_bus.ready)
   );

endmodule

`default_nettype wire

// ===== hdl/gb5_ctrl.sv =====
// Sequencer of the blur core: accepts an item and, when it completes a result, runs the divider and the 25 taps.
// Depends on gb5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gb5_ctrl #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  gb5_pkg::gb5_stat_type stat,
   output gb5_pkg::gb5_cmd_type  cmd
);
   import gb5_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
   localparam int DCW = $clog2(CW);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_EVAL, ST_DIV, ST_TAPS, ST_DRAIN, ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [DCW-1:0]   cnt_ff;
   logic [TAP_W-1:0] row_ff;
   logic [TAP_W-1:0] col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_CHECK;
            end
            ST_CHECK: state_ff <= ST_EVAL;
            ST_EVAL: begin
               cnt_ff   <= '0;
               state_ff <= stat.out_due ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DCW'(CW - 1)) begin
                  row_ff   <= '0;
                  col_ff   <= '0;
                  state_ff <= ST_TAPS;
               end
            end
            ST_TAPS: begin
               if (col_ff == TAP_LAST) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 1'b1;
                  if (row_ff == TAP_LAST) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DCW'(2)) state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (stat.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd           = '0;
      cmd.latch     = req_ready && req_valid;
      cmd.check     = (state_ff == ST_CHECK);
      cmd.div_start = (state_ff == ST_EVAL) && stat.out_due;
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.acc_clear = (state_ff == ST_DIV);
      cmd.tap_go    = (state_ff == ST_TAPS);
      cmd.tap_row   = row_ff;
      cmd.tap_col   = col_ff;
      cmd.load_out  = (state_ff == ST_FINISH) && stat.out_free;
   end

endmodule

`default_nettype wire

// ===== hdl/gb5_datapath.sv =====
// Datapath of the blur core: frame counter, line history memory, row/column
// divider, tap address and multiply-accumulate pipeline, output register.
// Depends on gb5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gb5_datapath #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire                           clock,
   input  wire                           reset,
   input  gb5_pkg::gb5_cmd_type          cmd,
   output gb5_pkg::gb5_stat_type         stat,
   input  wire [gb5_pkg::SIZE_W-1:0]     frame_width,
   input  wire [gb5_pkg::SIZE_W-1:0]     frame_height,
   input  wire [gb5_pkg::WEIGHT_W-1:0]   weight_center,
   input  wire [gb5_pkg::WEIGHT_W-1:0]   weight_near,
   input  wire [gb5_pkg::WEIGHT_W-1:0]   weight_far,
   input  wire                           in_op,
   input  wire [gb5_pkg::PIX_W-1:0]      in_pixel,
   output logic                          out_valid,
   output logic [gb5_pkg::PIX_W-1:0]     out_pixel,
   output logic                          out_last,
   input  wire                           out_ready
);
   import gb5_pkg::*;

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int CW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
   localparam int AW    = $clog2(4 * MAX_WIDTH + 8);
   localparam int DEPTH = 1 << AW;

   // Effective frame sizes and derived counts.
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [CW-1:0] npix, lag;
   logic [WW-1:0] w_eff_ff;
   logic [HW-1:0] h_eff_ff;
   logic [CW-1:0] npix_ff, lag_ff, total_ff;

   always_comb begin
      if (frame_width == '0)                          w_eff = WW'(1);
      else if (32'(frame_width) > 32'(MAX_WIDTH))     w_eff = WW'(MAX_WIDTH);
      else                                            w_eff = WW'(frame_width);
      if (frame_height == '0)                         h_eff = HW'(1);
      else if (32'(frame_height) > 32'(MAX_HEIGHT))   h_eff = HW'(MAX_HEIGHT);
      else                                            h_eff = HW'(frame_height);
      npix = CW'(w_eff) * CW'(h_eff);
      lag  = CW'({w_eff, 1'b0}) + CW'(2);
   end

   always_ff @(posedge clock) begin
      w_eff_ff <= w_eff;
      h_eff_ff <= h_eff;
      npix_ff  <= npix;
      lag_ff   <= lag;
      total_ff <= npix + lag;
   end

   // Item latch and frame position.
   logic [PIX_W-1:0] pix_ff;
   logic [CW-1:0]    t_ff, k_ff, t_eff, t_inc;
   logic             out_due_ff, due;

   always_comb begin
      t_eff = (t_ff >= total_ff) ? '0 : t_ff;
      t_inc = t_eff + 1'b1;
      due   = (t_eff >= lag_ff) && ((t_eff - lag_ff) < npix_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) pix_ff <= (in_op == OP_FLUSH) ? '0 : in_pixel;
      if (cmd.check) k_ff <= t_eff - lag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff       <= '0;
         out_due_ff <= 1'b0;
      end else if (cmd.check) begin
         t_ff       <= (t_inc >= total_ff) ? '0 : t_inc;
         out_due_ff <= due;
      end
   end

   // Restoring divider: k / width gives row in the quotient, column in the remainder.
   logic [WW-1:0] rem_ff;
   logic [CW-1:0] quo_ff;
   logic [WW:0]   trial, diff;
   logic          ge;

   always_comb begin
      trial = {rem_ff, quo_ff[CW-1]};
      diff  = trial - {1'b0, w_eff_ff};
      ge    = (trial >= {1'b0, w_eff_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= k_ff;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? diff[WW-1:0] : trial[WW-1:0];
         quo_ff <= {quo_ff[CW-2:0], ge};
      end
   end

   // Tap address with clamped coordinates.
   logic [HW-1:0]    row, hmax, y;
   logic [WW-1:0]    col, wmax, x;
   logic [HW+1:0]    ys;
   logic [WW+1:0]    xs;
   logic [HW+WW-1:0] addr_full;
   logic [WPROD_W-1:0] wprod;

   always_comb begin
      row  = quo_ff[HW-1:0];
      col  = rem_ff;
      hmax = h_eff_ff - 1'b1;
      wmax = w_eff_ff - 1'b1;
      ys   = (HW+2)'(row) + (HW+2)'(cmd.tap_row) - (HW+2)'(TAP_HALF);
      xs   = (WW+2)'(col) + (WW+2)'(cmd.tap_col) - (WW+2)'(TAP_HALF);
      if (ys[HW+1])                     y = '0;
      else if (ys[HW:0] > {1'b0, hmax}) y = hmax;
      else                              y = ys[HW-1:0];
      if (xs[WW+1])                     x = '0;
      else if (xs[WW:0] > {1'b0, wmax}) x = wmax;
      else                              x = xs[WW-1:0];
      addr_full = (HW+WW)'(y) * (HW+WW)'(w_eff_ff) + (HW+WW)'(x);
      wprod = weight_sel(cmd.tap_row, weight_center, weight_near, weight_far)
            * weight_sel(cmd.tap_col, weight_center, weight_near, weight_far);
   end

   // History memory and MAC pipeline.
   logic [PIX_W-1:0]   mem [DEPTH];
   logic [AW-1:0]      addr_ff;
   logic [PIX_W-1:0]   rd_ff;
   logic [WPROD_W-1:0] wp_ff, wp1_ff;
   logic [TERM_W-1:0]  term_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic               v0_ff, v1_ff, v2_ff;

   always_ff @(posedge clock) begin
      if (cmd.check && (t_eff < npix_ff)) mem[t_eff[AW-1:0]] <= pix_ff;
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_full[AW-1:0];
      wp_ff   <= wprod;
      wp1_ff  <= wp_ff;
      term_ff <= wp1_ff * rd_ff;
      if (cmd.acc_clear)  acc_ff <= '0;
      else if (v2_ff)     acc_ff <= acc_ff + ACC_W'(term_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.tap_go;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid <= 1'b1;
      end else if (out_ready) begin
         out_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_pixel <= (|acc_ff[ACC_W-1:FRAC_W+PIX_W]) ? '1 : acc_ff[FRAC_W+PIX_W-1:FRAC_W];
         out_last  <= (k_ff == npix_ff - 1'b1);
      end
   end

   assign stat.out_due  = out_due_ff;
   assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== hdl/gb5_checker.sv =====
// Port-level checks for the blur core, attached to the top level by bind.
// Depends on gaussian_blur_5x5_stream_core and the stream interfaces.
`timescale 1ns / 1ps
`default_nettype none

module gb5_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_pixel,
   input wire       rsp_last,
   input wire       csr_pready
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel) && $stable(rsp_last))
      else $error("stalled response changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while an item is in work");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without an item in work");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind gaussian_blur_5x5_stream_core gb5_checker u_gb5_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_pixel  (rsp_bus.blurred_pixel),
   .rsp_last   (rsp_bus.last),
   .csr_pready (csr_pready)
);

`default_nettype wire
